FILE: design/irpw_pkg.sv
// Package for the infrared pulse-width transmitter: beat types, phase codes,
// timing constants and the bit count / pause length tables. No dependencies.
package irpw_pkg;

    localparam int unsigned RemWidth = 7;
    localparam int unsigned BitsWidth = 4;
    localparam int unsigned DataWidth = 9;

    localparam logic [RemWidth-1:0] PresyncOnMs  = 7'd3;
    localparam logic [RemWidth-1:0] PresyncOffMs = 7'd6;
    localparam logic [RemWidth-1:0] SyncShortMs  = 7'd3;
    localparam logic [RemWidth-1:0] SyncLongMs   = 7'd6;
    localparam logic [RemWidth-1:0] BitGapMs     = 7'd2;
    localparam logic [RemWidth-1:0] BitZeroMs    = 7'd1;
    localparam logic [RemWidth-1:0] BitOneMs     = 7'd2;
    localparam logic [RemWidth-1:0] MaxPauseMs   = 7'd80;
    localparam logic [BitsWidth-1:0] MaxBits     = 4'd9;

    // Request kinds
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    // Next phase to start when the countdown expires
    typedef enum logic [2:0] {
        PH_PRESYNC     = 3'd0,
        PH_PRESYNC_GAP = 3'd1,
        PH_SYNC        = 3'd2,
        PH_BIT_GAP     = 3'd3,
        PH_BIT_MARK    = 3'd4,
        PH_PAUSE       = 3'd5
    } phase_t;

    typedef struct packed {
        logic                 req_type;
        logic                 beacon_header;
        logic [1:0]           length_code;
        logic [DataWidth-1:0] payload;
        logic [1:0]           pause_kind;
    } req_t;

    typedef struct packed {
        logic led_on;
        logic busy_res;
        logic accepted;
    } res_t;

    function automatic logic [BitsWidth-1:0] bit_count(input logic [1:0] code);
        logic [BitsWidth-1:0] n;
        unique case (code)
            2'd0:    n = 4'd5;
            2'd1:    n = 4'd7;
            2'd2:    n = 4'd8;
            default: n = 4'd9;
        endcase
        return n;
    endfunction

    // Pause kind three means no pause at all
    function automatic logic [RemWidth-1:0] pause_len(input logic [1:0] code);
        logic [RemWidth-1:0] n;
        unique case (code)
            2'd0:    n = 7'd25;
            2'd1:    n = 7'd56;
            2'd2:    n = 7'd80;
            default: n = 7'd0;
        endcase
        return n;
    endfunction

endpackage

FILE: design/irpw_if.sv
// Valid/ready channel interfaces for request and result beats.
// Depends on irpw_pkg for the beat types.
interface irpw_req_if;
    import irpw_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface irpw_res_if;
    import irpw_pkg::*;
    logic valid;
    logic ready;
    res_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: design/ir_pulse_width_transmitter_core.sv
// Infrared pulse-width transmitter core: phase sequencer and result register.
// Depends on irpw_pkg and the channel interfaces in irpw_if.sv.
//
// Every request beat is either a 1 ms tick or a packet load, and each one
// gives exactly one result beat with the emitter level, the busy flag and
// whether a load was taken. A load is taken only while no packet is in
// flight; it latches the header kind, bit count, data bits and pause kind
// but does not touch the timer, so the pre-sync starts on the first tick
// that leaves the countdown at zero. The frame is: pre-sync on 3 ms, off
// 6 ms, sync on 3 ms (6 ms beacon), then per data bit LSB first off 2 ms
// and on 1 ms (zero) or 2 ms (one), then a closing pause off 25/56/80 ms (or none).
// Busy drops as the closing pause starts, so a new load is taken during
// the pause and its pre-sync waits for the pause to run out.
// The state update and the result are worked out in the cycle the request
// is accepted and land in the result register; one beat per clock is
// sustained while the sink keeps taking results, and the request side
// stalls only while a result waits.
module ir_pulse_width_transmitter_core (
    input  logic clk,
    input  logic rst_n,
    irpw_req_if.sink   req,
    irpw_res_if.source res
);
    import irpw_pkg::*;

    // Sequencer state
    logic [RemWidth-1:0]  remaining_reg, remaining_next;
    phase_t               phase_reg, phase_next;
    logic [BitsWidth-1:0] bits_left_reg, bits_left_next;
    logic [DataWidth-1:0] shift_bits_reg, shift_bits_next;
    logic                 long_sync_reg, long_sync_next;
    logic [1:0]           count_code_reg, count_code_next;
    logic [1:0]           pause_code_reg, pause_code_next;
    logic                 sending_reg, sending_next;
    logic                 lit_reg, lit_next;
    logic                 took;

    // Result register
    logic res_valid_reg;
    res_t res_data_reg;
    res_t res_data_next;

    logic                in_fire;
    logic [RemWidth-1:0] rem_dec;
    logic                expire;

    // Take a new request whenever the result slot is free or draining
    assign req.ready = !res_valid_reg || res.ready;
    assign in_fire   = req.valid && req.ready;

    assign rem_dec = (remaining_reg != '0) ? RemWidth'(remaining_reg - 7'd1) : remaining_reg;
    assign expire  = sending_reg && (rem_dec == '0);

    // Next state for one request beat
    always_comb
    begin
        remaining_next  = remaining_reg;
        phase_next      = phase_reg;
        bits_left_next  = bits_left_reg;
        shift_bits_next = shift_bits_reg;
        long_sync_next  = long_sync_reg;
        count_code_next = count_code_reg;
        pause_code_next = pause_code_reg;
        sending_next    = sending_reg;
        lit_next        = lit_reg;
        took            = 1'b0;

        if (req.data.req_type == REQ_LOAD)
        begin
            if (!sending_reg)
            begin
                long_sync_next  = req.data.beacon_header;
                count_code_next = req.data.length_code;
                shift_bits_next = req.data.payload;
                pause_code_next = req.data.pause_kind;
                phase_next      = PH_PRESYNC;
                sending_next    = 1'b1;
                took            = 1'b1;
            end
        end
        else
        begin
            remaining_next = rem_dec;
            if (expire)
            begin
                unique case (phase_reg)
                    PH_PRESYNC:
                    begin
                        lit_next       = 1'b1;
                        remaining_next = PresyncOnMs;
                        phase_next     = PH_PRESYNC_GAP;
                    end
                    PH_PRESYNC_GAP:
                    begin
                        lit_next       = 1'b0;
                        remaining_next = PresyncOffMs;
                        phase_next     = PH_SYNC;
                    end
                    PH_SYNC:
                    begin
                        lit_next       = 1'b1;
                        remaining_next = long_sync_reg ? SyncLongMs : SyncShortMs;
                        bits_left_next = bit_count(count_code_reg);
                        phase_next     = PH_BIT_GAP;
                    end
                    PH_BIT_GAP:
                    begin
                        lit_next       = 1'b0;
                        remaining_next = BitGapMs;
                        phase_next     = PH_BIT_MARK;
                    end
                    PH_BIT_MARK:
                    begin
                        lit_next       = 1'b1;
                        remaining_next = shift_bits_reg[0] ? BitOneMs : BitZeroMs;
                        bits_left_next = BitsWidth'(bits_left_reg - 4'd1);
                        if (bits_left_next != '0)
                        begin
                            shift_bits_next = shift_bits_reg >> 1;
                            phase_next      = PH_BIT_GAP;
                        end
                        else
                        begin
                            phase_next = PH_PAUSE;
                        end
                    end
                    default:
                    begin
                        // Closing pause, or an unused phase code: end the packet
                        if (phase_reg == PH_PAUSE)
                        begin
                            remaining_next = pause_len(pause_code_reg);
                        end
                        lit_next        = 1'b0;
                        sending_next    = 1'b0;
                        shift_bits_next = '0;
                        long_sync_next  = 1'b0;
                        count_code_next = '0;
                        pause_code_next = '0;
                        phase_next      = PH_PRESYNC;
                    end
                endcase
            end
        end
    end

    // Result fields follow the updated state
    always_comb
    begin
        res_data_next.led_on   = lit_next;
        res_data_next.busy_res = sending_next;
        res_data_next.accepted = took;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg  <= '0;
            phase_reg      <= PH_PRESYNC;
            bits_left_reg  <= '0;
            shift_bits_reg <= '0;
            long_sync_reg  <= 1'b0;
            count_code_reg <= '0;
            pause_code_reg <= '0;
            sending_reg    <= 1'b0;
            lit_reg        <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                remaining_reg  <= remaining_next;
                phase_reg      <= phase_next;
                bits_left_reg  <= bits_left_next;
                shift_bits_reg <= shift_bits_next;
                long_sync_reg  <= long_sync_next;
                count_code_reg <= count_code_next;
                pause_code_reg <= pause_code_next;
                sending_reg    <= sending_next;
                lit_reg        <= lit_next;
                res_valid_reg  <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: load with each accepted request
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            res_data_reg <= res_data_next;
        end
    end

    assign res.valid = res_valid_reg;
    assign res.data  = res_data_reg;

    // A load seen while idle is taken and shows busy
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (req.data.req_type == REQ_LOAD) && !sending_reg
        |=> res_data_reg.accepted && res_data_reg.busy_res)
        else $error("idle load not taken");

    // Ticks never report a taken load
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (req.data.req_type == REQ_TICK) |=> !res_data_reg.accepted)
        else $error("tick reported as accepted load");

    // Countdown never exceeds the longest pause
    assert property (@(posedge clk) disable iff (!rst_n)
        remaining_reg <= MaxPauseMs)
        else $error("countdown out of range");

    // Bit counter never exceeds nine
    assert property (@(posedge clk) disable iff (!rst_n)
        bits_left_reg <= MaxBits)
        else $error("bit counter out of range");

    // With no packet in flight the sequencer waits at pre-sync, emitter dark
    assert property (@(posedge clk) disable iff (!rst_n)
        !sending_reg |-> (phase_reg == PH_PRESYNC) && !lit_reg)
        else $error("idle sequencer not parked");

endmodule

FILE: tb/sv/ir_pulse_width_transmitter_core_tb.sv
// Testbench for ir_pulse_width_transmitter_core: random and directed tick/load
// beats, with a built-in frame predictor checking every result beat.
// Depends on irpw_pkg, irpw_if.sv and the core RTL.
module ir_pulse_width_transmitter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import irpw_pkg::*;

    localparam int unsigned RandomBeats  = 400;
    localparam int unsigned CycleLimit   = 400000;
    localparam int unsigned DrainLimit   = 4000;
    localparam int unsigned SettleCycles = 16;
    localparam int unsigned MaxReported  = 10;

    logic clk = 1'b0;
    logic rst_n;

    irpw_req_if req_ch ();
    irpw_res_if res_ch ();

    ir_pulse_width_transmitter_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    always #4 clk = ~clk;

    // Request beats waiting for the driver, and status beats the core owes us
    req_t pending_q[$];
    res_t expected_status_q[$];

    int unsigned total_beats = 0;
    int unsigned sent_cnt = 0;
    int unsigned accepted_cnt = 0;
    int unsigned err_cnt = 0;
    int unsigned cycle_cnt = 0;
    logic        req_taken = 1'b0;

    // Shadow of the transmitter: countdown, next phase, latched packet fields
    logic [RemWidth-1:0]  ms_left     = '0;
    phase_t               next_phase  = PH_PRESYNC;
    logic [BitsWidth-1:0] bits_to_go  = '0;
    logic [DataWidth-1:0] data_sr     = '0;
    logic                 beacon_q    = 1'b0;
    logic [1:0]           len_q       = '0;
    logic [1:0]           pause_q     = '0;
    logic                 busy_q      = 1'b0;
    logic                 led_q       = 1'b0;

    // Closing pause has started (or a bogus phase was seen): emitter off, clear the latches
    function automatic void drop_packet();
        led_q      = 1'b0;
        busy_q     = 1'b0;
        data_sr    = '0;
        beacon_q   = 1'b0;
        len_q      = '0;
        pause_q    = '0;
        next_phase = PH_PRESYNC;
    endfunction

    // Apply one accepted beat to the shadow and return the status it should produce
    function automatic res_t advance_transmitter(input req_t beat);
        res_t status;
        logic took;
        took = 1'b0;
        if (beat.req_type == REQ_LOAD)
        begin
            // A load only latches; the timer and emitter are left alone
            if (!busy_q)
            begin
                beacon_q   = beat.beacon_header;
                len_q      = beat.length_code;
                data_sr    = beat.payload;
                pause_q    = beat.pause_kind;
                next_phase = PH_PRESYNC;
                busy_q     = 1'b1;
                took       = 1'b1;
            end
        end
        else
        begin
            if (ms_left != '0)
                ms_left = ms_left - 7'd1;
            if (busy_q && ms_left == '0)
            begin
                case (next_phase)
                    PH_PRESYNC:
                    begin
                        led_q      = 1'b1;
                        ms_left    = PresyncOnMs;
                        next_phase = PH_PRESYNC_GAP;
                    end
                    PH_PRESYNC_GAP:
                    begin
                        led_q      = 1'b0;
                        ms_left    = PresyncOffMs;
                        next_phase = PH_SYNC;
                    end
                    PH_SYNC:
                    begin
                        led_q   = 1'b1;
                        ms_left = beacon_q ? SyncLongMs : SyncShortMs;
                        case (len_q)
                            2'd0:    bits_to_go = 4'd5;
                            2'd1:    bits_to_go = 4'd7;
                            2'd2:    bits_to_go = 4'd8;
                            default: bits_to_go = 4'd9;
                        endcase
                        next_phase = PH_BIT_GAP;
                    end
                    PH_BIT_GAP:
                    begin
                        led_q      = 1'b0;
                        ms_left    = BitGapMs;
                        next_phase = PH_BIT_MARK;
                    end
                    PH_BIT_MARK:
                    begin
                        led_q      = 1'b1;
                        ms_left    = data_sr[0] ? BitOneMs : BitZeroMs;
                        bits_to_go = bits_to_go - 4'd1;
                        if (bits_to_go != '0)
                        begin
                            data_sr    = data_sr >> 1;
                            next_phase = PH_BIT_GAP;
                        end
                        else
                        begin
                            next_phase = PH_PAUSE;
                        end
                    end
                    PH_PAUSE:
                    begin
                        case (pause_q)
                            2'd0:    ms_left = 7'd25;
                            2'd1:    ms_left = 7'd56;
                            2'd2:    ms_left = MaxPauseMs;
                            default: ms_left = '0;
                        endcase
                        drop_packet();
                    end
                    default:
                    begin
                        drop_packet();
                    end
                endcase
            end
        end
        status.led_on   = led_q;
        status.busy_res = busy_q;
        status.accepted = took;
        return status;
    endfunction

    // Ticks from a load (core idle, timer at zero) until busy drops
    function automatic int frame_ticks(input logic beacon, input logic [1:0] len,
                                       input logic [DataWidth-1:0] bits);
        int n;
        int total;
        case (len)
            2'd0:    n = 5;
            2'd1:    n = 7;
            2'd2:    n = 8;
            default: n = 9;
        endcase
        total = 1 + int'(PresyncOnMs) + int'(PresyncOffMs)
                + int'(beacon ? SyncLongMs : SyncShortMs);
        for (int i = 0; i < n; i++)
            total += int'(BitGapMs) + int'(bits[i] ? BitOneMs : BitZeroMs);
        return total;
    endfunction

    function automatic int closing_ms(input logic [1:0] kind);
        case (kind)
            2'd0:    return 25;
            2'd1:    return 56;
            2'd2:    return int'(MaxPauseMs);
            default: return 0;
        endcase
    endfunction

    // Ticks carry random junk in the unused fields so every bit toggles
    task automatic queue_tick();
        req_t beat;
        beat               = req_t'($urandom);
        beat.req_type      = REQ_TICK;
        pending_q.push_back(beat);
    endtask

    task automatic queue_load(input logic beacon, input logic [1:0] len,
                              input logic [DataWidth-1:0] bits, input logic [1:0] kind);
        req_t beat;
        beat.req_type      = REQ_LOAD;
        beat.beacon_header = beacon;
        beat.length_code   = len;
        beat.payload       = bits;
        beat.pause_kind    = kind;
        pending_q.push_back(beat);
    endtask

    // Idling: the run is split into four equal stretches by beats sent: no idling,
    // sender idle 80%, receiver stalling 80%, both 30%. A recurring window of the
    // cycle count has no idling at all.
    function automatic logic roll_idle(input logic sender_side);
        int unsigned mode;
        int unsigned pct;
        mode = (total_beats == 0) ? 0 : (sent_cnt * 4) / total_beats;
        if (mode > 3)
            mode = 3;
        if (sender_side)
            pct = (mode == 1) ? 80 : (mode == 3) ? 30 : 0;
        else
            pct = (mode == 2) ? 80 : (mode == 3) ? 30 : 0;
        if ((cycle_cnt % 256) < 32)
            pct = 0;
        return $urandom_range(0, 99) < pct;
    endfunction

    // Driver: change inputs on the falling edge. Hold a beat until the rising
    // edge monitor reports it taken, then advance to the next one or idle.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (!req_ch.valid || req_taken)
            begin
                req_taken = 1'b0;
                if (pending_q.size() != 0 && !roll_idle(1'b1))
                begin
                    req_ch.valid <= 1'b1;
                    req_ch.data  <= pending_q.pop_front();
                    sent_cnt++;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
            res_ch.ready <= !roll_idle(1'b0);
        end
    end

    // Monitor: sample both channels on the rising edge. An accepted request
    // beat advances the shadow and queues its status; an accepted result beat
    // is checked against the oldest queued status.
    always @(posedge clk)
    begin
        res_t want;
        cycle_cnt <= cycle_cnt + 1;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                req_taken = 1'b1;
                accepted_cnt++;
                expected_status_q.push_back(advance_transmitter(req_ch.data));
            end
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_status_q.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= MaxReported)
                        $display("%0t: unexpected result beat: led=%b busy=%b acc=%b",
                                 $realtime, res_ch.data.led_on, res_ch.data.busy_res,
                                 res_ch.data.accepted);
                end
                else
                begin
                    want = expected_status_q.pop_front();
                    if (res_ch.data.led_on !== want.led_on
                        || res_ch.data.busy_res !== want.busy_res
                        || res_ch.data.accepted !== want.accepted)
                    begin
                        err_cnt++;
                        if (err_cnt <= MaxReported)
                            $display({"%0t: led exp %b got %b, busy exp %b got %b, ",
                                      "acc exp %b got %b"},
                                     $realtime, want.led_on, res_ch.data.led_on,
                                     want.busy_res, res_ch.data.busy_res,
                                     want.accepted, res_ch.data.accepted);
                    end
                end
            end
        end
    end

    // Watchdog: end the run as failed once the cycle limit is reached
    initial
    begin
        while (cycle_cnt < CycleLimit)
            @(posedge clk);
        $display("Mismatches found");
        $finish;
    end

    // Stimulus and end of run
    initial
    begin
        logic                 beacon;
        logic [1:0]           len;
        logic [DataWidth-1:0] bits;
        logic [1:0]           kind;
        int                   n_ticks;
        int                   stray_at;
        int unsigned          counted;
        int unsigned          drain;

        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        res_ch.ready = 1'b0;
        rst_n        = 1'b0;

        // Directed: ticks while idle, a load with every field at its top value
        // (beacon, nine ones, no timed pause), a load refused while busy,
        // and a few ticks into the pre-sync
        queue_tick();
        queue_tick();
        queue_load(1'b1, 2'd3, 9'h1FF, 2'd3);
        queue_load(1'b0, 2'd0, 9'h000, 2'd0);
        for (int i = 0; i < 6; i++)
            queue_tick();
        queue_load(1'b1, 2'd3, 9'h1FF, 2'd2);
        for (int i = 0; i < 4; i++)
            queue_tick();
        counted = pending_q.size();

        // Random frames: load, then enough ticks to finish the frame and land
        // somewhere in or after the closing pause. Now and then cut a frame short
        // (its successor's load gets refused) or drop a stray load among its ticks.
        while (counted < RandomBeats + 14)
        begin
            beacon  = 1'($urandom_range(0, 1));
            len     = 2'($urandom_range(0, 3));
            bits    = DataWidth'($urandom);
            kind    = ($urandom_range(0, 2) == 0) ? 2'($urandom_range(1, 2))
                                                  : ($urandom_range(0, 1) ? 2'd0 : 2'd3);
            n_ticks = frame_ticks(beacon, len, bits);
            if ($urandom_range(0, 9) == 0)
                n_ticks = $urandom_range(1, n_ticks - 1);
            else
                n_ticks += $urandom_range(0, closing_ms(kind) + 2);
            stray_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, n_ticks) : 0;
            queue_load(beacon, len, bits, kind);
            counted++;
            for (int i = 1; i <= n_ticks; i++)
            begin
                queue_tick();
                counted++;
                if (i == stray_at)
                    queue_load(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                               DataWidth'($urandom), 2'($urandom_range(0, 3)));
            end
        end
        total_beats = pending_q.size();

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Wait for every beat to go in, then for the owed results, with a bound
        while (accepted_cnt < total_beats)
            @(posedge clk);
        drain = 0;
        while (expected_status_q.size() != 0 && drain < DrainLimit)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (SettleCycles) @(posedge clk);
        if (expected_status_q.size() != 0)
        begin
            $display("%0d expected result beats never arrived", expected_status_q.size());
            err_cnt += expected_status_q.size();
        end

        if (err_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: ir_pulse_width_transmitter_core.f
design/irpw_pkg.sv
design/irpw_if.sv
design/ir_pulse_width_transmitter_core.sv
tb/sv/ir_pulse_width_transmitter_core_tb.sv
